### rtl/bale_pkg.sv
// Package for the bounded array list engine.
// Holds the sizes, request and result types, operation and status codes,
// and the controller state type. No dependencies.
`default_nettype none

package bale_pkg;

    // List capacity and derived widths
    localparam int DEPTH  = 8;
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int DATA_W = 32;
    localparam int POS_W  = 4;
    localparam int PW     = (AW + 1 > POS_W) ? AW + 1 : POS_W;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4,
        OP_DELETE     = 3'd5,
        OP_SEARCH     = 3'd6
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHUP,
        S_HEAD,
        S_SHDN,
        S_SCAN,
        S_DUMP,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [1:0]               status;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] data;
        logic                     last;
    } res_t;

    // 1-based position of an entry index, wrapped to the field width
    function automatic logic [POS_W-1:0] pos_of(input logic [AW-1:0] idx);
        logic [PW-1:0] p;
        p = PW'(idx) + PW'(1);
        return p[POS_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/bale_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and held while no read is issued. No dependencies.
`default_nettype none

module bale_ram #(
    parameter int WIDTH = 32,
    parameter int WORDS = 8
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic                                       re,
    input  wire logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/bale_ctrl.sv
// Sequencer of the bounded array list engine: decodes requests, walks the
// entry RAM for shifts, scans and dumps, and keeps the entry count.
// Depends on bale_pkg.
`default_nettype none

module bale_ctrl (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire bale_pkg::req_t              req,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    output bale_pkg::res_t                   c_res,
    output logic                             c_valid,
    input  wire logic                        c_ready,
    output logic                             mem_we,
    output logic [bale_pkg::AW-1:0]          mem_waddr,
    output logic [bale_pkg::DATA_W-1:0]      mem_wdata,
    output logic                             mem_re,
    output logic [bale_pkg::AW-1:0]          mem_raddr,
    input  wire logic [bale_pkg::DATA_W-1:0] mem_rdata
);

    import bale_pkg::*;

    state_t              state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [DATA_W-1:0]   v_reg, v_next;
    logic                srch_reg, srch_next;
    logic [1:0]          status_reg, status_next;
    logic [POS_W-1:0]    pos_reg, pos_next;

    logic [AW-1:0]       idx_inc;
    logic [CW-1:0]       count_dec;
    logic                idx_last;
    logic                full;
    logic                empty;

    assign idx_inc   = idx_reg + AW'(1);
    assign count_dec = count_reg - CW'(1);
    assign idx_last  = ((CW'(idx_reg) + CW'(1)) == count_reg);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        v_reg      <= v_next;
        srch_reg   <= srch_next;
        status_reg <= status_next;
        pos_reg    <= pos_next;
    end

    // Next state, RAM access and result
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        v_next      = v_reg;
        srch_next   = srch_reg;
        status_next = status_reg;
        pos_next    = pos_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = v_reg;
        mem_re      = 1'b0;
        mem_raddr   = '0;
        req_stall   = (state_reg != S_IDLE);
        c_valid     = 1'b0;
        c_res       = '{status: status_reg, position: pos_reg, data: v_reg, last: 1'b1};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    v_next      = req.value;
                    srch_next   = (req.req_type == OP_SEARCH);
                    status_next = ST_OK;
                    pos_next    = '0;
                    unique case (req.req_type)
                        OP_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                                state_next  = S_RESP;
                            end
                            else if (empty)
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = '0;
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                                state_next = S_RESP;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = count_dec[AW-1:0];
                                idx_next   = count_dec[AW-1:0];
                                state_next = S_SHUP;
                            end
                        end
                        OP_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = count_reg[AW-1:0];
                                mem_wdata  = req.value;
                                count_next = count_reg + CW'(1);
                            end
                            state_next = S_RESP;
                        end
                        OP_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else if (count_reg == CW'(1))
                            begin
                                count_next = count_dec;
                                state_next = S_RESP;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = AW'(1);
                                idx_next   = AW'(1);
                                state_next = S_SHDN;
                            end
                        end
                        OP_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                count_next = count_dec;
                            end
                            state_next = S_RESP;
                        end
                        OP_DUMP, OP_DELETE, OP_SEARCH:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                                state_next  = S_RESP;
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = '0;
                                idx_next   = '0;
                                state_next = (req.req_type == OP_DUMP) ? S_DUMP : S_SCAN;
                            end
                        end
                        default:
                        begin
                            // undefined code: dropped without a result
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Shift up: entry idx moves to idx+1, walking towards the head
            S_SHUP:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_inc;
                mem_wdata = mem_rdata;
                if (idx_reg == '0)
                begin
                    state_next = S_HEAD;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_reg - AW'(1);
                    idx_next  = idx_reg - AW'(1);
                end
            end

            // New word into the freed head slot
            S_HEAD:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = v_reg;
                count_next = count_reg + CW'(1);
                state_next = S_RESP;
            end

            // Shift down: entry idx moves to idx-1, walking towards the tail
            S_SHDN:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = mem_rdata;
                if (idx_last)
                begin
                    count_next = count_dec;
                    state_next = S_RESP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end

            // Linear scan for the first match
            S_SCAN:
            begin
                if (mem_rdata == v_reg)
                begin
                    if (srch_reg)
                    begin
                        pos_next   = pos_of(idx_reg);
                        state_next = S_RESP;
                    end
                    else if (idx_last)
                    begin
                        count_next = count_dec;
                        state_next = S_RESP;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = idx_inc;
                        idx_next   = idx_inc;
                        state_next = S_SHDN;
                    end
                end
                else if (idx_last)
                begin
                    status_next = ST_NOTFOUND;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = idx_inc;
                    idx_next  = idx_inc;
                end
            end

            // One result per entry, read data held until taken
            S_DUMP:
            begin
                c_valid = 1'b1;
                c_res   = '{status: ST_OK, position: pos_of(idx_reg),
                            data: mem_rdata, last: idx_last};
                if (c_ready)
                begin
                    if (idx_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = idx_inc;
                        idx_next  = idx_inc;
                    end
                end
            end

            S_RESP:
            begin
                c_valid = 1'b1;
                if (c_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above capacity");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("read and write to one entry in the same cycle");

    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP || state_reg == S_SCAN || state_reg == S_SHDN)
            |-> (count_reg != '0))
        else $error("list walk on an empty list");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && state_reg != S_HEAD && state_reg != S_SHDN
            && state_reg != S_SCAN) |=> (count_reg == $past(count_reg)))
        else $error("count changed outside an update step");

endmodule

`default_nettype wire

### rtl/bounded_array_list_engine.sv
// Push back, pop back and status-only cases go straight to the result. With n
// entries held, push front on a non-empty list shifts them up, then writes the
// head, pop front shifts the rest down, and search/delete scan up to n entries.
// Dump gives one result per entry, one per cycle while not stalled.
// One request at a time: the next is taken the cycle after the last result leaves the controller.
// Reset clears the count and the control state; the entry RAM is not cleared.
`default_nettype none

module bounded_array_list_engine (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire bale_pkg::req_t req,
    input  wire logic           req_valid,
    output logic                req_stall,
    output bale_pkg::res_t      res,
    output logic                res_valid,
    input  wire logic           res_stall
);

    import bale_pkg::*;

    res_t              c_res;
    logic              c_valid;
    logic              c_ready;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              out_v_reg, out_v_next;
    res_t              out_reg, out_next;

    bale_ram #(
        .WIDTH (DATA_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bale_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .c_res     (c_res),
        .c_valid   (c_valid),
        .c_ready   (c_ready),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    // Output register: loads when empty or being drained
    assign c_ready = !out_v_reg || !res_stall;

    always_comb
    begin
        out_v_next = out_v_reg;
        out_next   = out_reg;
        if (c_ready)
        begin
            out_v_next = c_valid;
            if (c_valid)
            begin
                out_next = c_res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_v_reg;
    assign res       = out_reg;

endmodule

`default_nettype wire
